FILE: src/hash_tree_sector_locator_defines.svh
// Assertion macros for the hash tree sector locator.
// Included by the top level; ASSERT_OFF removes every check.
`ifndef HASH_TREE_SECTOR_LOCATOR_DEFINES_SVH
`define HASH_TREE_SECTOR_LOCATOR_DEFINES_SVH

`ifndef ASSERT_OFF
// Clocked check, masked while reset is high
`define HTS_ASSERT(name, prop, msg) \
  name: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
// Clocked check that also holds through reset
`define HTS_ASSERT_ALWAYS(name, prop, msg) \
  name: assert property (@(posedge clk) prop) else $error(msg);
`else
`define HTS_ASSERT(name, prop, msg)
`define HTS_ASSERT_ALWAYS(name, prop, msg)
`endif

`endif

FILE: src/hts_pkg.sv
// Shared widths and sequencer state type for the hash tree sector locator.
// No dependencies; used by the channel interfaces and the top level.
`default_nettype none

package hts_pkg;

  // Field widths of the request and result channels
  localparam int SECTOR_INDEX_W = 32;
  localparam int PLAIN_SIZE_W   = 45;
  localparam int SECTOR_BYTES_W = 13;
  localparam int OFFSET_W       = 45;
  localparam int LEVELS_W       = 3;
  localparam int CRYPTO_SIZE_W  = 46;

  // Sequencer steps around the shared adder
  typedef enum logic [3:0] {
    ST_IDLE,
    ST_RANGE,
    ST_DATA_WALK,
    ST_SIZE_PREP,
    ST_SIZE_DEC,
    ST_SIZE_WALK,
    ST_TREE_ADD,
    ST_TREE_N,
    ST_MASTER,
    ST_TAG_START,
    ST_TAG_FULL1,
    ST_TAG_FULL2,
    ST_TAG_WALK,
    ST_TAG_SLOT,
    ST_DONE
  } state_t;

endpackage

`default_nettype wire

FILE: src/hts_req_if.sv
// Request channel: sector index and plain file size with valid/ready.
// Depends on hts_pkg for field widths.
`default_nettype none

interface hts_req_if;
  logic                               valid;
  logic                               ready;
  logic [hts_pkg::SECTOR_INDEX_W-1:0] sector_index;
  logic [hts_pkg::PLAIN_SIZE_W-1:0]   plain_size;

  modport source (output valid, output sector_index, output plain_size, input ready);
  modport sink   (input valid, input sector_index, input plain_size, output ready);
endinterface

`default_nettype wire

FILE: src/hts_rsp_if.sv
// Result channel: sector location, tree level count and encrypted size.
// Depends on hts_pkg for field widths.
`default_nettype none

interface hts_rsp_if;
  logic                               valid;
  logic                               ready;
  logic                               in_range;
  logic [hts_pkg::SECTOR_BYTES_W-1:0] sector_bytes;
  logic [hts_pkg::OFFSET_W-1:0]       data_offset;
  logic [hts_pkg::OFFSET_W-1:0]       auth_offset;
  logic [hts_pkg::LEVELS_W-1:0]       tree_levels;
  logic [hts_pkg::CRYPTO_SIZE_W-1:0]  crypto_size;

  modport source (output valid, output in_range, output sector_bytes, output data_offset,
                  output auth_offset, output tree_levels, output crypto_size, input ready);
  modport sink   (input valid, input in_range, input sector_bytes, input data_offset,
                  input auth_offset, input tree_levels, input crypto_size, output ready);
endinterface

`default_nettype wire

FILE: src/hash_tree_sector_locator.sv
// Channel  | Dir | Handshake   | Payload
// req      | in  | valid/ready | sector_index, plain_size
// rsp      | out | valid/ready | in_range, sector_bytes, data_offset, auth_offset,
//          |     |             | tree_levels, crypto_size
//
// A request runs from the edge that takes it until the sequencer is idle again, through
// the base-FANOUT digit walks of the sector index, the last sector and the tag group and
// a tree add and a tree count step per tree level, all stepped through one shared
// add/sub unit. A leaf tag in the short last tag sector skips the full-layout steps; an
// empty file skips the size and tree steps.
// req.ready is high only while the sequencer is idle; a finished result waits in the
// output register, so the next request may start while rsp is stalled, and it holds in
// its final step only while that register is still full.
// Synchronous reset clears the sequencer and the output valid flag.
// Depends on hts_pkg, hts_req_if, hts_rsp_if and the assertion macro header.
`default_nettype none
`include "hash_tree_sector_locator_defines.svh"

module hash_tree_sector_locator #(
  parameter int SECTOR_BYTES = 4096,
  parameter int TAG_BYTES    = 32,
  parameter int MAX_LEVELS   = 6
) (
  input  wire logic   clk,
  input  wire logic   rst,
  hts_req_if.sink     req,
  hts_rsp_if.source   rsp
);

  localparam int LSB    = $clog2(SECTOR_BYTES);
  localparam int LTB    = $clog2(TAG_BYTES);
  localparam int LF     = LSB - LTB;
  localparam int FANOUT = SECTOR_BYTES / TAG_BYTES;
  localparam int AW0    = hts_pkg::SECTOR_INDEX_W + LSB + 2;
  localparam int AW     = (AW0 > hts_pkg::CRYPTO_SIZE_W + 1) ? AW0 : hts_pkg::CRYPTO_SIZE_W + 1;
  localparam int BW     = $clog2(SECTOR_BYTES + 1);
  localparam int LVW    = $clog2(MAX_LEVELS + 1);

  hts_pkg::state_t state, state_next;

  // Request and working registers
  logic [hts_pkg::SECTOR_INDEX_W-1:0] idx_r;
  logic [hts_pkg::PLAIN_SIZE_W-1:0]   size_r;
  logic [AW-1:0]                      acc;
  logic [AW-1:0]                      walk;
  logic [AW-1:0]                      n_r;
  logic [AW-1:0]                      data_r;
  logic [AW-1:0]                      last0;
  logic [AW-1:0]                      crypto_r;
  logic [AW-1:0]                      auth_r;
  logic [LVW-1:0]                     levels_r;
  logic [BW-1:0]                      bytes_r;
  logic                               inr_r;

  // Output register
  logic                               out_valid;
  logic                               out_in_range;
  logic [hts_pkg::SECTOR_BYTES_W-1:0] out_bytes;
  logic [hts_pkg::OFFSET_W-1:0]       out_data;
  logic [hts_pkg::OFFSET_W-1:0]       out_auth;
  logic [hts_pkg::LEVELS_W-1:0]       out_levels;
  logic [hts_pkg::CRYPTO_SIZE_W-1:0]  out_crypto;

  // Shared add/sub unit
  logic [AW-1:0] unit_a, unit_b;
  logic          unit_sub;
  logic [AW:0]   unit_res;
  logic [AW-1:0] unit_sum;
  logic          unit_carry;

  assign unit_res   = {1'b0, unit_a} + {1'b0, unit_b ^ {AW{unit_sub}}} + (AW + 1)'(unit_sub);
  assign unit_sum   = unit_res[AW-1:0];
  assign unit_carry = unit_res[AW];

  // Derived values of the held request
  logic [AW-1:0] start;
  logic [AW-1:0] size_ext;
  logic [AW-1:0] grp;
  logic [AW-1:0] walk_sh;
  logic          walk_more;
  logic [AW-1:0] tree_sz;
  logic [AW-1:0] last_sec;
  logic [AW-1:0] last_grp;
  logic          grp_dec;
  logic          last_hit;
  logic          out_free;

  assign start     = AW'(idx_r) << LSB;
  assign size_ext  = AW'(size_r);
  assign grp       = AW'(idx_r) >> LF;
  assign walk_sh   = walk >> LF;
  assign walk_more = walk >= AW'(FANOUT);
  assign tree_sz   = (n_r[LF-1:0] == '0) ? AW'(FANOUT) : AW'(n_r[LF-1:0]);
  assign last_sec  = size_ext >> LSB;
  assign last_grp  = last_sec >> LF;
  assign grp_dec   = (last_sec[LF-1:0] == '0) && (last_grp != '0);
  assign last_hit  = (unit_sum == grp);
  assign out_free  = !out_valid || rsp.ready;

  assign req.ready = (state == hts_pkg::ST_IDLE);

  // Next state
  always_comb begin
    state_next = state;
    case (state)
      hts_pkg::ST_IDLE:      if (req.valid) state_next = hts_pkg::ST_RANGE;
      hts_pkg::ST_RANGE:     state_next = hts_pkg::ST_DATA_WALK;
      hts_pkg::ST_DATA_WALK: begin
        if (!walk_more) begin
          state_next = (size_r == '0) ? hts_pkg::ST_TAG_START : hts_pkg::ST_SIZE_PREP;
        end
      end
      hts_pkg::ST_SIZE_PREP: state_next = hts_pkg::ST_SIZE_DEC;
      hts_pkg::ST_SIZE_DEC:  state_next = hts_pkg::ST_SIZE_WALK;
      hts_pkg::ST_SIZE_WALK: if (!walk_more) state_next = hts_pkg::ST_TREE_ADD;
      hts_pkg::ST_TREE_ADD:  state_next = hts_pkg::ST_TREE_N;
      hts_pkg::ST_TREE_N: begin
        if (unit_sum > AW'(1) && levels_r < LVW'(MAX_LEVELS)) begin
          state_next = hts_pkg::ST_TREE_ADD;
        end else begin
          state_next = hts_pkg::ST_MASTER;
        end
      end
      hts_pkg::ST_MASTER:    state_next = hts_pkg::ST_TAG_START;
      hts_pkg::ST_TAG_START: begin
        state_next = last_hit ? hts_pkg::ST_TAG_SLOT : hts_pkg::ST_TAG_FULL1;
      end
      hts_pkg::ST_TAG_FULL1: state_next = hts_pkg::ST_TAG_FULL2;
      hts_pkg::ST_TAG_FULL2: state_next = hts_pkg::ST_TAG_WALK;
      hts_pkg::ST_TAG_WALK:  if (!walk_more) state_next = hts_pkg::ST_TAG_SLOT;
      hts_pkg::ST_TAG_SLOT:  state_next = hts_pkg::ST_DONE;
      hts_pkg::ST_DONE:      if (out_free) state_next = hts_pkg::ST_IDLE;
      default:               state_next = hts_pkg::ST_IDLE;
    endcase
  end

  // Operand selection for the shared unit
  always_comb begin
    unit_a   = acc;
    unit_b   = '0;
    unit_sub = 1'b0;
    case (state)
      hts_pkg::ST_RANGE: begin
        unit_a   = size_ext;
        unit_b   = start;
        unit_sub = 1'b1;
      end
      hts_pkg::ST_DATA_WALK, hts_pkg::ST_SIZE_WALK, hts_pkg::ST_TAG_WALK: begin
        unit_b = walk_sh << LSB;
      end
      hts_pkg::ST_SIZE_PREP: begin
        unit_a = size_ext;
        unit_b = AW'(SECTOR_BYTES - 1);
      end
      hts_pkg::ST_SIZE_DEC: begin
        unit_a   = walk;
        unit_b   = AW'(1);
        unit_sub = 1'b1;
      end
      hts_pkg::ST_TREE_ADD:  unit_b = tree_sz << LTB;
      hts_pkg::ST_TREE_N: begin
        unit_a = n_r >> LF;
        unit_b = AW'(n_r[LF-1:0] != '0);
      end
      hts_pkg::ST_MASTER:    unit_b = (size_ext > AW'(SECTOR_BYTES)) ? AW'(TAG_BYTES) : '0;
      hts_pkg::ST_TAG_START: begin
        unit_a   = last_grp;
        unit_b   = AW'(grp_dec);
        unit_sub = 1'b1;
      end
      hts_pkg::ST_TAG_FULL1: unit_b = grp << LSB;
      hts_pkg::ST_TAG_FULL2: unit_b = AW'(FANOUT) << LSB;
      hts_pkg::ST_TAG_SLOT:  unit_b = AW'(idx_r[LF-1:0]) << LTB;
      default: begin
        unit_a   = acc;
        unit_b   = '0;
        unit_sub = 1'b0;
      end
    endcase
  end

  // Sequencer state
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= hts_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Working registers: one adder result taken per step
  always_ff @(posedge clk) begin
    case (state)
      hts_pkg::ST_IDLE: begin
        if (req.valid) begin
          idx_r  <= req.sector_index;
          size_r <= req.plain_size;
        end
      end
      hts_pkg::ST_RANGE: begin
        inr_r    <= unit_carry && (unit_sum != '0);
        bytes_r  <= (unit_carry && (unit_sum != '0)) ?
                    ((unit_sum < AW'(SECTOR_BYTES)) ? BW'(unit_sum) : BW'(SECTOR_BYTES)) :
                    '0;
        acc      <= start;
        walk     <= AW'(idx_r);
        levels_r <= '0;
        last0    <= '0;
        crypto_r <= '0;
      end
      hts_pkg::ST_DATA_WALK: begin
        if (walk_more) begin
          walk <= walk_sh;
          acc  <= unit_sum;
        end else begin
          data_r <= acc;
        end
      end
      hts_pkg::ST_SIZE_PREP: begin
        walk <= unit_sum >> LSB;
        n_r  <= unit_sum >> LSB;
      end
      hts_pkg::ST_SIZE_DEC: begin
        walk <= unit_sum;
        acc  <= size_ext;
      end
      hts_pkg::ST_SIZE_WALK: begin
        if (walk_more) begin
          walk <= walk_sh;
          acc  <= unit_sum;
        end else begin
          last0 <= acc;
        end
      end
      hts_pkg::ST_TREE_ADD: begin
        acc      <= unit_sum;
        levels_r <= levels_r + LVW'(1);
      end
      hts_pkg::ST_TREE_N:    n_r <= unit_sum;
      hts_pkg::ST_MASTER:    crypto_r <= unit_sum;
      hts_pkg::ST_TAG_START: begin
        acc  <= last_hit ? last0 : (grp << (LSB + LF));
        walk <= grp;
      end
      hts_pkg::ST_TAG_FULL1, hts_pkg::ST_TAG_FULL2: acc <= unit_sum;
      hts_pkg::ST_TAG_WALK: begin
        if (walk_more) begin
          walk <= walk_sh;
          acc  <= unit_sum;
        end
      end
      hts_pkg::ST_TAG_SLOT:  auth_r <= unit_sum;
      default: begin
      end
    endcase
  end

  // Output register: load when the result is done and the slot is free
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (state == hts_pkg::ST_DONE && out_free) begin
      out_valid <= 1'b1;
    end else if (rsp.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state == hts_pkg::ST_DONE && out_free) begin
      out_in_range <= inr_r;
      out_bytes    <= hts_pkg::SECTOR_BYTES_W'(bytes_r);
      out_data     <= data_r[hts_pkg::OFFSET_W-1:0];
      out_auth     <= auth_r[hts_pkg::OFFSET_W-1:0];
      out_levels   <= hts_pkg::LEVELS_W'(levels_r);
      out_crypto   <= crypto_r[hts_pkg::CRYPTO_SIZE_W-1:0];
    end
  end

  assign rsp.valid        = out_valid;
  assign rsp.in_range     = out_in_range;
  assign rsp.sector_bytes = out_bytes;
  assign rsp.data_offset  = out_data;
  assign rsp.auth_offset  = out_auth;
  assign rsp.tree_levels  = out_levels;
  assign rsp.crypto_size  = out_crypto;

  // Checks
  `HTS_ASSERT(a_new_result_from_done, $rose(rsp.valid) |-> $past(state) == hts_pkg::ST_DONE, "result raised outside the final step")
  `HTS_ASSERT(a_out_of_range_empty, rsp.valid && !rsp.in_range |-> rsp.sector_bytes == '0, "out of range sector reports bytes")
  `HTS_ASSERT(a_empty_tree_no_size, rsp.valid && rsp.tree_levels == '0 |-> rsp.crypto_size == '0, "empty tree with nonzero size")
  `HTS_ASSERT_ALWAYS(a_levels_bounded, state == hts_pkg::ST_TREE_N |-> levels_r <= LVW'(MAX_LEVELS), "tree level count overran")

endmodule

`default_nettype wire
